[sv/sem_pkg.sv]
`default_nettype none

package sem_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned REG_W  = 13;
  localparam int unsigned GRAD_W = 11;
  localparam int unsigned SQ_W   = 20;
  localparam int unsigned ROOT_W = 16;
  localparam int unsigned ROOT_STEPS = 8;

  localparam logic [REG_W-1:0] REG_RESET_VAL = 13'd4096;
  localparam logic [REG_W-1:0] HEIGHT_MIN    = 13'd3;
  localparam logic [REG_W-1:0] HEIGHT_MAX    = 13'd4096;
  localparam logic [PIX_W-1:0] EDGE_MAX      = 8'd255;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } sem_col_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } sem_pos_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic              sat;
    sem_pos_t          pos;
  } sem_item_t;

endpackage

`default_nettype wire

[sv/sem_line_store.sv]
`default_nettype none

module sem_line_store
  import sem_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output logic      [2*PIX_W-1:0]   rd_data_o,
  input  wire logic                 wr_en_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire logic [2*PIX_W-1:0]   wr_data_i
);

  // word holds {upper row, middle row}
  logic [2*PIX_W-1:0] mem_q [DEPTH];
  logic [2*PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[sv/sem_window.sv]
`default_nettype none

module sem_window
  import sem_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     shift_i,
  input  wire sem_col_t                 col_i,
  output logic signed [GRAD_W-1:0]      gx_o,
  output logic signed [GRAD_W-1:0]      gy_o
);

  sem_col_t old_q;
  sem_col_t prev_q;

  function automatic logic signed [GRAD_W-1:0] ext(input logic [PIX_W-1:0] v);
    ext = $signed({{(GRAD_W-PIX_W){1'b0}}, v});
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_q  <= '0;
      prev_q <= '0;
    end else if (shift_i) begin
      old_q  <= prev_q;
      prev_q <= col_i;
    end
  end

  assign gx_o = (ext(col_i.top) - ext(old_q.top))
              + ((ext(col_i.mid) - ext(old_q.mid)) <<< 1)
              + (ext(col_i.bot) - ext(old_q.bot));

  assign gy_o = (ext(old_q.top) + (ext(prev_q.top) <<< 1) + ext(col_i.top))
              - (ext(old_q.bot) + (ext(prev_q.bot) <<< 1) + ext(col_i.bot));

endmodule

`default_nettype wire

[sv/sem_sqrt_cell.sv]
`default_nettype none

module sem_sqrt_cell
  import sem_pkg::*;
#(
  parameter int unsigned BIT_POS = 14
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire sem_item_t in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output sem_item_t      out_item_o
);

  localparam logic [ROOT_W:0] StepBit = (ROOT_W+1)'(1) << BIT_POS;

  logic            valid_q;
  sem_item_t       item_q;
  sem_item_t       item_d;
  logic [ROOT_W:0] trial;
  logic            take;

  always_comb begin
    trial  = {1'b0, in_item_i.root} + StepBit;
    take   = {1'b0, in_item_i.rem} >= trial;
    item_d = in_item_i;
    if (take) begin
      item_d.rem  = in_item_i.rem - trial[ROOT_W-1:0];
      item_d.root = (in_item_i.root >> 1) + StepBit[ROOT_W-1:0];
    end else begin
      item_d.root = in_item_i.root >> 1;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

[sv/sobel_edge_magnitude_top.sv]
// Channel   | Dir | Signals                               | Payload
// s_axis    | in  | s_axis_tvalid/tready/tdata[7:0]        | pixel
// m_axis    | out | m_axis_tvalid/tready/tdata[31:0]/tlast | edge_value, centre_row,
//           |     |                                        | centre_col; tlast = frame_last
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_data_i        | image_width, image_height
//
// Sustained rate is one pixel per cycle while m_axis_tready is high; a result
// passes in order through line store read, gradient, square, sum, eight root cells.
// Reset clears stage valids, counters, window and registers; the line store is
// not cleared, rows 0 and 1 of each frame fill it before it is used.
// Back-pressure ripples stage by stage, so empty stages keep taking pixels.
`default_nettype none

module sobel_edge_magnitude_top
  import sem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] pixel
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [31:0]      m_axis_tdata,   // [7:0] edge_value, [19:8] centre_row,
                                                // [31:20] centre_col
  output logic                  m_axis_tlast,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [REG_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned LW = (CW + 1 > REG_W) ? CW + 1 : REG_W;

  logic [REG_W-1:0] width_q;
  logic [REG_W-1:0] height_q;
  logic [LW-1:0]    w_eff;
  logic [REG_W-1:0] h_eff;
  logic [CW-1:0]    col_q;
  logic [POS_W-1:0] row_q;
  logic             col_last;
  logic             row_last;
  logic             accept;
  logic [CW-1:0]    col_m1;

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [CW-1:0]    s1_col_q;
  logic             s1_emit_q;
  sem_pos_t         s1_pos_q;
  logic             s1_go;
  logic [2*PIX_W-1:0] rd_data;
  sem_col_t         s1_column;
  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;

  logic                     s2_valid_q;
  logic                     s2_ready;
  logic signed [GRAD_W-1:0] s2_gx_q;
  logic signed [GRAD_W-1:0] s2_gy_q;
  sem_pos_t                 s2_pos_q;
  logic signed [2*GRAD_W-1:0] prod_x;
  logic signed [2*GRAD_W-1:0] prod_y;

  logic             s3_valid_q;
  logic             s3_ready;
  logic [SQ_W-1:0]  s3_sqx_q;
  logic [SQ_W-1:0]  s3_sqy_q;
  sem_pos_t         s3_pos_q;
  logic [SQ_W:0]    sq_sum;

  logic             s4_valid_q;
  logic             s4_ready;
  sem_item_t        s4_item_q;
  sem_item_t        s4_item_d;

  logic      cell_valid [ROOT_STEPS+1];
  logic      cell_ready [ROOT_STEPS+1];
  sem_item_t cell_item  [ROOT_STEPS+1];
  sem_item_t out_item;

  // effective frame size
  always_comb begin
    if (LW'(width_q) < LW'(3)) begin
      w_eff = LW'(3);
    end else if (LW'(width_q) > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = LW'(width_q);
    end
    if (height_q < HEIGHT_MIN) begin
      h_eff = HEIGHT_MIN;
    end else if (height_q > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = height_q;
    end
  end

  assign col_last = (LW'(col_q) + LW'(1)) >= w_eff;
  assign row_last = (REG_W'(row_q) + REG_W'(1)) >= h_eff;
  assign col_m1   = col_q - CW'(1);

  // request intake and stage 1
  assign s1_go         = s1_valid_q && (!s1_emit_q || s2_ready);
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= REG_RESET_VAL;
      height_q   <= REG_RESET_VAL;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_IMAGE_WIDTH: begin
            width_q <= cfg_data_i;
            col_q   <= '0;
            row_q   <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            height_q <= cfg_data_i;
            col_q    <= '0;
            row_q    <= '0;
          end
          default: ;
        endcase
      end else if (accept) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_last ? '0 : row_q + POS_W'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q       <= s_axis_tdata;
      s1_col_q      <= col_q;
      s1_emit_q     <= (row_q >= POS_W'(2)) && (col_q >= CW'(2));
      s1_pos_q.row  <= row_q - POS_W'(1);
      s1_pos_q.col  <= POS_W'(col_m1);
      s1_pos_q.last <= row_last && col_last;
    end
  end

  sem_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({rd_data[PIX_W-1:0], s1_px_q})
  );

  assign s1_column.top = rd_data[2*PIX_W-1:PIX_W];
  assign s1_column.mid = rd_data[PIX_W-1:0];
  assign s1_column.bot = s1_px_q;

  sem_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_go),
    .col_i   (s1_column),
    .gx_o    (gx),
    .gy_o    (gy)
  );

  // stage 2: gradients, stage 3: squares, stage 4: sum and saturation
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s3_ready = !s3_valid_q || s4_ready;
  assign s4_ready = !s4_valid_q || cell_ready[0];

  assign prod_x = s2_gx_q * s2_gx_q;
  assign prod_y = s2_gy_q * s2_gy_q;
  assign sq_sum = {1'b0, s3_sqx_q} + {1'b0, s3_sqy_q};

  always_comb begin
    s4_item_d.rem  = sq_sum[ROOT_W-1:0];
    s4_item_d.root = '0;
    s4_item_d.sat  = |sq_sum[SQ_W:ROOT_W];
    s4_item_d.pos  = s3_pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_go && s1_emit_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_go && s1_emit_q) begin
      s2_gx_q  <= gx;
      s2_gy_q  <= gy;
      s2_pos_q <= s1_pos_q;
    end
    if (s3_ready && s2_valid_q) begin
      s3_sqx_q <= prod_x[SQ_W-1:0];
      s3_sqy_q <= prod_y[SQ_W-1:0];
      s3_pos_q <= s2_pos_q;
    end
    if (s4_ready && s3_valid_q) begin
      s4_item_q <= s4_item_d;
    end
  end

  // square root chain
  assign cell_valid[0] = s4_valid_q;
  assign cell_item[0]  = s4_item_q;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    sem_sqrt_cell #(
      .BIT_POS (2 * (ROOT_STEPS - 1 - k))
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cell_valid[k]),
      .in_ready_o  (cell_ready[k]),
      .in_item_i   (cell_item[k]),
      .out_valid_o (cell_valid[k+1]),
      .out_ready_i (cell_ready[k+1]),
      .out_item_o  (cell_item[k+1])
    );
  end

  assign out_item                 = cell_item[ROOT_STEPS];
  assign cell_ready[ROOT_STEPS]   = m_axis_tready;
  assign m_axis_tvalid            = cell_valid[ROOT_STEPS];
  assign m_axis_tdata[7:0]        = out_item.sat ? EDGE_MAX : out_item.root[PIX_W-1:0];
  assign m_axis_tdata[19:8]       = out_item.pos.row;
  assign m_axis_tdata[31:20]      = out_item.pos.col;
  assign m_axis_tlast             = out_item.pos.last;

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_go) |-> (s1_col_q != col_q))
    else $error("line store read and write hit the same column");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(col_q) < w_eff)
    else $error("column counter beyond active width");

  a_root_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_item.root[ROOT_W-1:PIX_W] == '0))
    else $error("square root exceeds pixel range");

  a_row_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_item.pos.row != '0))
    else $error("border row emitted");

  a_stage2_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(s2_valid_q)) |-> $past(s1_emit_q && s1_valid_q))
    else $error("gradient stage loaded from a non-interior pixel");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import sem_pkg::*;

  localparam int LINE_DEPTH    = 4096;
  localparam int DIM_MIN       = 3;
  localparam int DIM_MAX       = 4096;
  localparam int DRAIN_CYCLES  = 24;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PIXELS = 500;
  localparam int WIDE_PIXELS   = 48;
  localparam int TALL_PIXELS   = 60;
  localparam int MAX_REPORTS   = 30;

  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MASK, RX_BURSTY} rx_mode_e;
  typedef enum logic [1:0] {PX_NOISE, PX_BINARY, PX_RAMP, PX_FLAT} px_mode_e;

  typedef struct packed {
    logic [PIX_W-1:0] mag;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } edge_result_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;
  logic             m_axis_tlast;
  logic             cfg_we_i      = 1'b0;
  logic [1:0]       cfg_idx_i     = '0;
  logic [REG_W-1:0] cfg_data_i    = '0;

  sobel_edge_magnitude_top #(.MAX_WIDTH(LINE_DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [PIX_W-1:0] line_up  [LINE_DEPTH];
  logic [PIX_W-1:0] line_mid [LINE_DEPTH];
  logic [PIX_W-1:0] win_px   [6];
  int               pos_row = 0;
  int               pos_col = 0;
  logic [REG_W-1:0] width_reg  = REG_RESET_VAL;
  logic [REG_W-1:0] height_reg = REG_RESET_VAL;

  logic [PIX_W-1:0] pixel_q [$];
  edge_result_t     pending_edges [$];
  int               pixels_outstanding = 0;
  bit               req_fire = 1'b0;

  int errors      = 0;
  int pixels_sent = 0;
  int edges_seen  = 0;
  int frame_ends  = 0;
  int reg_writes  = 0;
  int idle_cycles = 0;

  int          burst_left = 0;
  int          gap_left   = 0;
  rx_mode_e    rx_mode    = RX_OPEN;
  logic [15:0] rx_mask    = '1;
  int          rx_tick    = 0;
  int          rx_hold    = 0;

  function automatic int clamp_dim(input logic [REG_W-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] root_floor(input int unsigned v);
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] t;
    int unsigned      sq;
    r = '0;
    for (int b = PIX_W - 1; b >= 0; b--) begin
      t  = r | (8'd1 << b);
      sq = int'(t) * int'(t);
      if (sq <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] gradient_mag(input int gx, input int gy);
    int unsigned s;
    s = gx * gx + gy * gy;
    if (s >= 65536) return EDGE_MAX;
    return root_floor(s);
  endfunction

  function automatic bit sobel_advance(input logic [PIX_W-1:0] px, output edge_result_t res);
    int w;
    int h;
    int gx;
    int gy;
    int p [3][3];
    bit hit;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    for (int k = 0; k < 3; k++) begin
      p[k][0] = win_px[k];
      p[k][1] = win_px[3 + k];
    end
    p[0][2] = line_up[pos_col];
    p[1][2] = line_mid[pos_col];
    p[2][2] = px;
    hit = (pos_row >= 2) && (pos_col >= 2);
    res = '0;
    if (hit) begin
      gx = (p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
      gy = (p[0][0] + 2 * p[0][1] + p[0][2]) - (p[2][0] + 2 * p[2][1] + p[2][2]);
      res.mag  = gradient_mag(gx, gy);
      res.row  = POS_W'(pos_row - 1);
      res.col  = POS_W'(pos_col - 1);
      res.last = (pos_row == h - 1) && (pos_col == w - 1);
    end
    line_up[pos_col]  = line_mid[pos_col];
    line_mid[pos_col] = px;
    for (int k = 0; k < 3; k++) begin
      win_px[k]     = win_px[3 + k];
      win_px[3 + k] = PIX_W'(p[k][2]);
    end
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
    return hit;
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = val;
        pos_row   = 0;
        pos_col   = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = val;
        pos_row    = 0;
        pos_col    = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // monitor: requests in, register writes, results out, watchdog
  always @(posedge clk_i) begin
    edge_result_t want;
    edge_result_t got;
    bit           out_fire;
    if (rst_ni) begin
      req_fire = s_axis_tvalid && s_axis_tready;
      out_fire = m_axis_tvalid && m_axis_tready;
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_data_i);
      if (req_fire) begin
        pixels_outstanding--;
        pixels_sent++;
        if (sobel_advance(s_axis_tdata, want)) pending_edges.push_back(want);
      end
      if (out_fire) begin
        got = {m_axis_tdata[7:0], m_axis_tdata[19:8], m_axis_tdata[31:20], m_axis_tlast};
        edges_seen++;
        if (got.last) frame_ends++;
        if (pending_edges.size() == 0) begin
          report_mismatch($sformatf("unexpected result row %0d col %0d", got.row, got.col));
        end else begin
          want = pending_edges.pop_front();
          check_field("edge_value", want.mag, got.mag);
          check_field("centre_row", want.row, got.row);
          check_field("centre_col", want.col, got.col);
          check_field("frame_last", want.last, got.last);
        end
      end
      if (req_fire || out_fire || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
          $display("tb_top failed");
          $finish;
        end
      end
    end
  end

  // driver: pixel requests in bursts, result back-pressure by mode
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || req_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          s_axis_tdata  <= pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (rx_tick % 64 == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mask = 16'($urandom);
      end
      rx_tick++;
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: m_axis_tready <= 1'b1;
          RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
          RX_MASK: m_axis_tready <= rx_mask[4'(rx_tick % 16)];
          default: begin
            if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(4, 30);
            m_axis_tready <= (rx_hold == 0);
          end
        endcase
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    cfg_we_i   <= 1'b1;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
    reg_writes++;
  endtask

  task automatic queue_value(input logic [PIX_W-1:0] v);
    pixel_q.push_back(v);
    pixels_outstanding++;
  endtask

  task automatic queue_pixels(input int n);
    px_mode_e         mode;
    int               step;
    int               base;
    logic [PIX_W-1:0] v;
    mode = px_mode_e'($urandom_range(0, 3));
    step = $urandom_range(0, 40);
    base = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      case (mode)
        PX_NOISE:  v = PIX_W'($urandom_range(0, 255));
        PX_BINARY: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PX_RAMP:   v = PIX_W'(base + i * step + $urandom_range(0, 3));
        default:   v = PIX_W'(base + $urandom_range(0, 1));
      endcase
      queue_value(v);
    end
  endtask

  task automatic hold_for_results();
    while (pixels_outstanding != 0 || pending_edges.size() != 0) @(negedge clk_i);
  endtask

  task automatic wait_quiet();
    hold_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int small_pixels;
    int frame_px;
    int n;
    int split;
    bit wide_done;
    bit tall_done;
    small_pixels = 0;
    wide_done    = 1'b0;
    tall_done    = 1'b0;
    foreach (line_up[i]) begin
      line_up[i]  = '0;
      line_mid[i] = '0;
    end
    foreach (win_px[i]) win_px[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    // vertical step edge, clips
    for (int r = 0; r < 3; r++) begin
      queue_value(8'h00);
      queue_value(8'h00);
      queue_value(8'hFF);
    end
    // horizontal step edge, clips
    for (int c = 0; c < 3; c++) queue_value(8'hFF);
    for (int c = 0; c < 6; c++) queue_value(8'h00);
    // unclipped magnitude, with spare register writes mid-frame
    for (int i = 0; i < 4; i++) queue_value(8'(10 * (i + 1)));
    wait_quiet();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '0);
    for (int i = 4; i < 9; i++) queue_value(8'(10 * (i + 1)));

    while (small_pixels < RANDOM_PIXELS) begin
      wait_quiet();
      if (!wide_done && small_pixels > 150) begin
        wide_done = 1'b1;
        write_reg(REG_IMAGE_WIDTH, REG_W'($urandom_range(DIM_MAX + 1, (1 << REG_W) - 1)));
        write_reg(REG_IMAGE_HEIGHT, REG_W'(DIM_MIN));
        queue_pixels(WIDE_PIXELS);
        small_pixels += WIDE_PIXELS;
      end else if (!tall_done && small_pixels > 300) begin
        tall_done = 1'b1;
        write_reg(REG_IMAGE_WIDTH, REG_W'($urandom_range(0, DIM_MIN - 1)));
        write_reg(REG_IMAGE_HEIGHT, REG_W'(DIM_MAX));
        queue_pixels(TALL_PIXELS);
        small_pixels += TALL_PIXELS;
      end else begin
        case ($urandom_range(0, 7))
          0: write_reg(REG_IMAGE_WIDTH, REG_W'($urandom_range(0, DIM_MIN - 1)));
          1: write_reg(REG_IMAGE_HEIGHT, REG_W'($urandom_range(0, DIM_MIN - 1)));
          2: write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, REG_W'($urandom));
          3: write_reg(REG_IMAGE_WIDTH, REG_W'($urandom_range(DIM_MIN, 12)));
          4: write_reg(REG_IMAGE_HEIGHT, REG_W'($urandom_range(DIM_MIN, 8)));
          default: begin
            write_reg(REG_IMAGE_WIDTH, REG_W'($urandom_range(DIM_MIN, 9)));
            write_reg(REG_IMAGE_HEIGHT, REG_W'($urandom_range(DIM_MIN, 6)));
          end
        endcase
        if (clamp_dim(width_reg) * clamp_dim(height_reg) > 200) begin
          write_reg(REG_IMAGE_WIDTH, REG_W'($urandom_range(DIM_MIN, 9)));
          write_reg(REG_IMAGE_HEIGHT, REG_W'($urandom_range(DIM_MIN, 6)));
        end
        frame_px = clamp_dim(width_reg) * clamp_dim(height_reg);
        if ($urandom_range(0, 3) == 0) n = $urandom_range(1, frame_px + 5);
        else n = frame_px * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) begin
          split = $urandom_range(0, n);
          queue_pixels(split);
          hold_for_results();
          queue_pixels(n - split);
        end else begin
          queue_pixels(n);
        end
        small_pixels += n;
      end
    end

    wait_quiet();
    $display("sent %0d pixels, checked %0d edge results across %0d frame ends",
             pixels_sent, edges_seen, frame_ends);
    $display("%0d register writes incl. saturated, spare and 4096-wide/tall geometries",
             reg_writes);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
